// ===== design/wfs_pkg.sv =====
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types and constants for the wall-follow steering block: angle and
// speed constants, register indexes, the configuration and reading bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package wfs_pkg;

   // servo angles (degrees)
   localparam logic [7:0] ANGLE_MIN        = 8'd40;
   localparam logic [7:0] ANGLE_CENTER     = 8'd90;
   localparam logic [7:0] ANGLE_MAX        = 8'd140;
   localparam logic [7:0] ANGLE_HARD_LEFT  = 8'd65;
   localparam logic [7:0] ANGLE_HARD_RIGHT = 8'd115;
   localparam logic [7:0] ANGLE_TURN_LEFT  = 8'd60;
   localparam logic [7:0] ANGLE_TURN_RIGHT = 8'd120;

   // default drive speed, used outside a corner turn and under a danger override
   localparam logic [6:0] SPEED_DEFAULT = 7'd72;

   // side correction: round(err * 0.08) = (4*err + 25) / 50, capped
   localparam logic [4:0]  CORR_LIMIT   = 5'd25;
   // largest error whose correction is still within the cap
   localparam logic [13:0] GAIN_SAT_ERR = 14'd318;
   localparam logic [10:0] ROUND_BIAS   = 11'd25;
   // floor(x / 50) = (x * 1311) >> 16, exact for x below 1300
   localparam logic [10:0] RECIP_50     = 11'd1311;

   // register indexes on the csr port
   localparam logic [2:0] CSR_MIN_VALID     = 3'd0;
   localparam logic [2:0] CSR_MAX_VALID     = 3'd1;
   localparam logic [2:0] CSR_SIDE_REACT    = 3'd2;
   localparam logic [2:0] CSR_SIDE_DANGER   = 3'd3;
   localparam logic [2:0] CSR_SIDE_DEADZONE = 3'd4;
   localparam logic [2:0] CSR_FRONT_TURN    = 3'd5;
   localparam logic [2:0] CSR_MAX_STEP      = 3'd6;
   localparam logic [2:0] CSR_SPEED_TURN    = 3'd7;

   typedef struct packed {
      logic [13:0] range_lo_mm;
      logic [13:0] range_hi_mm;
      logic [13:0] wall_react_mm;
      logic [13:0] wall_danger_mm;
      logic [9:0]  wall_dead_band;
      logic [13:0] corner_dist_mm;
      logic [6:0]  max_step_deg;
      logic [6:0]  speed_turn_pct;
   } cfg_type;

   typedef struct packed {
      logic [13:0] front_dist_mm;
      logic [13:0] left_dist_mm;
      logic [13:0] right_dist_mm;
   } reading_type;

endpackage

`default_nettype wire

// ===== design/wall_follow_steering.sv =====
// ----------------------------------------------------------------------------
// wall_follow_steering
// Servo angle and drive speed from front, left and right range readings.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  front, left, right distance (mm)
//   rsp_      out        rsp_valid/rsp_ready  servo angle, speed percent
//   csr_      in         csr_wr_en            csr_index, csr_wdata
//
// One request per cycle sustained while results are taken; each request
// passes the input register, then steering logic into the result register.
// The last angle register is updated as each request enters the result
// register, so each request is steered from the angle of the one before it.
// Synchronous active-high reset clears valids, loads register defaults and
// centres the last angle. A stalled result holds both stages; req_ready
// stays high while the input stage is empty or can move on.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follow_steering (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [13:0] req_front_dist_mm,
   input  wire logic [13:0] req_left_dist_mm,
   input  wire logic [13:0] req_right_dist_mm,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_servo_angle,
   output logic      [6:0]  rsp_speed_pct,
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [13:0] csr_wdata
);

   wfs_pkg::cfg_type     cfg_ff;
   wfs_pkg::reading_type rd_ff, rd_in;
   logic                 s1_valid_ff;
   logic                 out_valid_ff;
   logic [7:0]           angle_ff, angle_in;
   logic [6:0]           speed_ff, speed_in;
   logic [7:0]           last_angle_ff;
   logic                 out_free;
   logic                 s1_move;

   // pipeline handshake
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   assign rd_in.front_dist_mm = req_front_dist_mm;
   assign rd_in.left_dist_mm  = req_left_dist_mm;
   assign rd_in.right_dist_mm = req_right_dist_mm;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.range_lo_mm    <= 14'd100;
         cfg_ff.range_hi_mm    <= 14'd8500;
         cfg_ff.wall_react_mm  <= 14'd600;
         cfg_ff.wall_danger_mm <= 14'd190;
         cfg_ff.wall_dead_band <= 10'd20;
         cfg_ff.corner_dist_mm <= 14'd530;
         cfg_ff.max_step_deg   <= 7'd4;
         cfg_ff.speed_turn_pct <= 7'd71;
      end else if (csr_wr_en) begin
         case (csr_index)
            wfs_pkg::CSR_MIN_VALID:     cfg_ff.range_lo_mm    <= csr_wdata;
            wfs_pkg::CSR_MAX_VALID:     cfg_ff.range_hi_mm    <= csr_wdata;
            wfs_pkg::CSR_SIDE_REACT:    cfg_ff.wall_react_mm  <= csr_wdata;
            wfs_pkg::CSR_SIDE_DANGER:   cfg_ff.wall_danger_mm <= csr_wdata;
            wfs_pkg::CSR_SIDE_DEADZONE: cfg_ff.wall_dead_band <= csr_wdata[9:0];
            wfs_pkg::CSR_FRONT_TURN:    cfg_ff.corner_dist_mm <= csr_wdata;
            wfs_pkg::CSR_MAX_STEP:      cfg_ff.max_step_deg   <= csr_wdata[6:0];
            wfs_pkg::CSR_SPEED_TURN:    cfg_ff.speed_turn_pct <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rd_ff <= rd_in;
      end
   end

   // steering logic
   wfs_steer u_steer (
      .cfg        (cfg_ff),
      .rd         (rd_ff),
      .last_angle (last_angle_ff),
      .angle      (angle_in),
      .speed      (speed_in)
   );

   // result stage and last angle
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         last_angle_ff <= wfs_pkg::ANGLE_CENTER;
      end else begin
         if (out_free) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (s1_move) begin
            last_angle_ff <= angle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         angle_ff <= angle_in;
         speed_ff <= speed_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_servo_angle = angle_ff;
   assign rsp_speed_pct   = speed_ff;

endmodule

`default_nettype wire

// ===== design/wfs_gain.sv =====
// ----------------------------------------------------------------------------
// wfs_gain
// Deadzoned proportional side correction: round(err * 0.08) limited to the
// correction cap, with err = side_react - side.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_gain (
   input  wire logic [13:0] side_mm,
   input  wire logic [13:0] react_mm,
   input  wire logic [9:0]  deadzone_mm,
   output logic      [4:0]  gain
);

   logic [13:0] err;
   logic [10:0] num;
   logic [21:0] prod;

   // error is only used when side lies below the react distance
   assign err  = react_mm - side_mm;
   assign num  = {err[8:0], 2'b00} + wfs_pkg::ROUND_BIAS;
   assign prod = {11'd0, num} * {11'd0, wfs_pkg::RECIP_50};

   always_comb begin
      if (err <= {4'd0, deadzone_mm}) begin
         gain = 5'd0;
      end else if (err > wfs_pkg::GAIN_SAT_ERR) begin
         gain = wfs_pkg::CORR_LIMIT;
      end else begin
         gain = prod[20:16];
      end
   end

endmodule

`default_nettype wire

// ===== design/wfs_steer.sv =====
// ----------------------------------------------------------------------------
// wfs_steer
// Steering decision for one reading set: validity window, corner turn, side
// correction, danger overrides, clamp and slew against the last angle.
// ----------------------------------------------------------------------------
`default_nettype none

module wfs_steer (
   input  wire wfs_pkg::cfg_type     cfg,
   input  wire wfs_pkg::reading_type rd,
   input  wire logic [7:0]           last_angle,
   output logic      [7:0]           angle,
   output logic      [6:0]           speed
);

   logic       fv, lv, rv;
   logic [13:0] f, l, r;
   logic       left_near, right_near;
   logic       sel_left, sel_right;
   logic [13:0] sel_mm;
   logic [4:0] gain;
   logic [7:0] side_tgt;
   logic [7:0] base_tgt, tgt;
   logic [6:0] spd;
   logic [9:0] up_lim, dn_lim, tgt_x;

   assign f = rd.front_dist_mm;
   assign l = rd.left_dist_mm;
   assign r = rd.right_dist_mm;

   // validity window
   assign fv = (f >= cfg.range_lo_mm) && (f <= cfg.range_hi_mm);
   assign lv = (l >= cfg.range_lo_mm) && (l <= cfg.range_hi_mm);
   assign rv = (r >= cfg.range_lo_mm) && (r <= cfg.range_hi_mm);

   assign left_near  = l < cfg.wall_react_mm;
   assign right_near = r < cfg.wall_react_mm;

   // pick the side that drives the correction; closer side wins, equal distances give none
   always_comb begin
      sel_left  = 1'b0;
      sel_right = 1'b0;
      if (lv && rv) begin
         if (left_near && (l < r)) begin
            sel_left = 1'b1;
         end else if (right_near && (r < l)) begin
            sel_right = 1'b1;
         end
      end else if (lv && left_near) begin
         sel_left = 1'b1;
      end else if (rv && right_near) begin
         sel_right = 1'b1;
      end
   end

   assign sel_mm = sel_left ? l : r;

   wfs_gain u_gain (
      .side_mm     (sel_mm),
      .react_mm    (cfg.wall_react_mm),
      .deadzone_mm (cfg.wall_dead_band),
      .gain        (gain)
   );

   always_comb begin
      if (sel_left) begin
         side_tgt = wfs_pkg::ANGLE_CENTER + {3'd0, gain};
      end else if (sel_right) begin
         side_tgt = wfs_pkg::ANGLE_CENTER - {3'd0, gain};
      end else begin
         side_tgt = wfs_pkg::ANGLE_CENTER;
      end
   end

   // corner turn or side correction, then danger overrides and clamp
   always_comb begin
      spd = wfs_pkg::SPEED_DEFAULT;
      if (fv && (f < cfg.corner_dist_mm)) begin
         spd = cfg.speed_turn_pct;
         if (rv && (!lv || (r > l))) begin
            base_tgt = wfs_pkg::ANGLE_TURN_RIGHT;
         end else if (lv) begin
            base_tgt = wfs_pkg::ANGLE_TURN_LEFT;
         end else begin
            base_tgt = last_angle;
         end
      end else begin
         base_tgt = side_tgt;
      end

      tgt = base_tgt;
      if (lv && (l < cfg.wall_danger_mm)) begin
         if (tgt < wfs_pkg::ANGLE_HARD_RIGHT) begin
            tgt = wfs_pkg::ANGLE_HARD_RIGHT;
         end
         spd = wfs_pkg::SPEED_DEFAULT;
      end
      if (rv && (r < cfg.wall_danger_mm)) begin
         if (tgt > wfs_pkg::ANGLE_HARD_LEFT) begin
            tgt = wfs_pkg::ANGLE_HARD_LEFT;
         end
         spd = wfs_pkg::SPEED_DEFAULT;
      end
      if (tgt < wfs_pkg::ANGLE_MIN) begin
         tgt = wfs_pkg::ANGLE_MIN;
      end
      if (tgt > wfs_pkg::ANGLE_MAX) begin
         tgt = wfs_pkg::ANGLE_MAX;
      end
   end

   // slew limit, signed 10-bit so the lower bound may go negative
   assign up_lim = {2'b00, last_angle} + {3'b000, cfg.max_step_deg};
   assign dn_lim = {2'b00, last_angle} - {3'b000, cfg.max_step_deg};
   assign tgt_x  = {2'b00, tgt};

   always_comb begin
      if (!fv && !lv && !rv) begin
         angle = last_angle;
         speed = wfs_pkg::SPEED_DEFAULT;
      end else begin
         speed = spd;
         if ($signed(tgt_x) > $signed(up_lim)) begin
            angle = up_lim[7:0];
         end else if ($signed(tgt_x) < $signed(dn_lim)) begin
            angle = dn_lim[7:0];
         end else begin
            angle = tgt;
         end
      end
   end

endmodule

`default_nettype wire

// ===== dv/wall_follow_steering_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_follow_steering_test
// Self-checking bench for the wall-follow steering block. A behavioural
// predictor tracks the register settings and the last servo angle, works out
// the angle and speed for every accepted request, and the checker compares
// each result against the oldest prediction. Directed requests cover the
// window edges, corner turns, danger zones and register extremes; random
// traffic then runs under several settings and idling patterns.
// ----------------------------------------------------------------------------

module wall_follow_steering_test;

   typedef struct packed {
      logic [7:0] angle;
      logic [6:0] speed;
   } steer_type;

   localparam wfs_pkg::cfg_type RESET_CFG = '{
      range_lo_mm: 14'd100, range_hi_mm: 14'd8500, wall_react_mm: 14'd600,
      wall_danger_mm: 14'd190, wall_dead_band: 10'd20, corner_dist_mm: 14'd530,
      max_step_deg: 7'd4, speed_turn_pct: 7'd71};

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic        req_valid         = 1'b0;
   logic [13:0] req_front_dist_mm = '0;
   logic [13:0] req_left_dist_mm  = '0;
   logic [13:0] req_right_dist_mm = '0;
   logic        rsp_ready         = 1'b0;
   logic        csr_wr_en         = 1'b0;
   logic [2:0]  csr_index         = '0;
   logic [13:0] csr_wdata         = '0;

   // block outputs
   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_servo_angle;
   logic [6:0]  rsp_speed_pct;

   // predictor state
   wfs_pkg::cfg_type active_cfg  = RESET_CFG;
   int               model_angle = int'(wfs_pkg::ANGLE_CENTER);
   steer_type        steer_q[$];

   // bookkeeping
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int items_sent         = 0;
   int results_seen       = 0;
   int mismatch_count     = 0;
   int settings_loaded    = 0;
   int turn_results       = 0;

   wall_follow_steering dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_front_dist_mm (req_front_dist_mm),
      .req_left_dist_mm  (req_left_dist_mm),
      .req_right_dist_mm (req_right_dist_mm),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_servo_angle   (rsp_servo_angle),
      .rsp_speed_pct     (rsp_speed_pct),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic in_window(input logic [13:0] d);
      return d >= active_cfg.range_lo_mm && d <= active_cfg.range_hi_mm;
   endfunction

   // deadzoned proportional correction, rounded half up, capped
   function automatic int side_gain(input logic [13:0] side);
      int err;
      int c;
      err = int'(active_cfg.wall_react_mm) - int'(side);
      if (err <= int'(active_cfg.wall_dead_band))
         return 0;
      c = (4 * err + 25) / 50;
      return (c > int'(wfs_pkg::CORR_LIMIT)) ? int'(wfs_pkg::CORR_LIMIT) : c;
   endfunction

   // angle and speed for one request; advances the model angle
   function automatic steer_type predict_steering(input logic [13:0] f, l, r);
      logic      fv, lv, rv;
      int        tgt;
      int        corr;
      int        step;
      steer_type res;
      fv = in_window(f);
      lv = in_window(l);
      rv = in_window(r);
      res.speed = wfs_pkg::SPEED_DEFAULT;
      // nothing usable: hold the angle, normal speed
      if (!fv && !lv && !rv) begin
         res.angle = model_angle[7:0];
         return res;
      end
      if (fv && f < active_cfg.corner_dist_mm) begin
         // corner: head for the more open side
         res.speed = active_cfg.speed_turn_pct;
         if (rv && (!lv || r > l))
            tgt = int'(wfs_pkg::ANGLE_TURN_RIGHT);
         else if (lv)
            tgt = int'(wfs_pkg::ANGLE_TURN_LEFT);
         else
            tgt = model_angle;
      end else begin
         corr = 0;
         if (lv && rv) begin
            if (l < active_cfg.wall_react_mm && l < r)
               corr = side_gain(l);
            else if (r < active_cfg.wall_react_mm && r < l)
               corr = -side_gain(r);
         end else if (lv && l < active_cfg.wall_react_mm) begin
            corr = side_gain(l);
         end else if (rv && r < active_cfg.wall_react_mm) begin
            corr = -side_gain(r);
         end
         tgt = int'(wfs_pkg::ANGLE_CENTER) + corr;
      end
      // very close walls override, left first
      if (lv && l < active_cfg.wall_danger_mm) begin
         if (tgt < int'(wfs_pkg::ANGLE_HARD_RIGHT))
            tgt = int'(wfs_pkg::ANGLE_HARD_RIGHT);
         res.speed = wfs_pkg::SPEED_DEFAULT;
      end
      if (rv && r < active_cfg.wall_danger_mm) begin
         if (tgt > int'(wfs_pkg::ANGLE_HARD_LEFT))
            tgt = int'(wfs_pkg::ANGLE_HARD_LEFT);
         res.speed = wfs_pkg::SPEED_DEFAULT;
      end
      if (tgt < int'(wfs_pkg::ANGLE_MIN)) tgt = int'(wfs_pkg::ANGLE_MIN);
      if (tgt > int'(wfs_pkg::ANGLE_MAX)) tgt = int'(wfs_pkg::ANGLE_MAX);
      // slew limit
      step = int'(active_cfg.max_step_deg);
      if (tgt > model_angle + step)
         model_angle = model_angle + step;
      else if (tgt < model_angle - step)
         model_angle = model_angle - step;
      else
         model_angle = tgt;
      res.angle = model_angle[7:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Receiver back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

   // ---------------------------------------------------------------------
   // Prediction on accept, result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%t mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      steer_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            steer_q.push_back(predict_steering(req_front_dist_mm, req_left_dist_mm,
                                               req_right_dist_mm));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (steer_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result angle %0d speed %0d",
                                         rsp_servo_angle, rsp_speed_pct));
            end else begin
               want = steer_q.pop_front();
               if (want.speed != wfs_pkg::SPEED_DEFAULT)
                  turn_results++;
               if (rsp_servo_angle !== want.angle)
                  report_mismatch($sformatf("servo_angle expected %0d got %0d",
                                            want.angle, rsp_servo_angle));
               if (rsp_speed_pct !== want.speed)
                  report_mismatch($sformatf("speed_pct expected %0d got %0d",
                                            want.speed, rsp_speed_pct));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------
   // one request, with a random idle gap in front of it
   task automatic send_reading(input logic [13:0] f, l, r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_front_dist_mm <= f;
      req_left_dist_mm  <= l;
      req_right_dist_mm <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // stop sending and wait until every request has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_seen < items_sent)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [13:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // write all registers while idle; narrow ones get junk in unused bits
   task automatic load_settings(input wfs_pkg::cfg_type c);
      logic [13:0] junk;
      junk = 14'($urandom_range(16383));
      wait_drained();
      write_register(wfs_pkg::CSR_MIN_VALID, c.range_lo_mm);
      write_register(wfs_pkg::CSR_MAX_VALID, c.range_hi_mm);
      write_register(wfs_pkg::CSR_SIDE_REACT, c.wall_react_mm);
      write_register(wfs_pkg::CSR_SIDE_DANGER, c.wall_danger_mm);
      write_register(wfs_pkg::CSR_SIDE_DEADZONE, {junk[13:10], c.wall_dead_band});
      write_register(wfs_pkg::CSR_FRONT_TURN, c.corner_dist_mm);
      write_register(wfs_pkg::CSR_MAX_STEP, {junk[13:7], c.max_step_deg});
      write_register(wfs_pkg::CSR_SPEED_TURN, {junk[13:7], c.speed_turn_pct});
      csr_wr_en  <= 1'b0;
      active_cfg = c;
      settings_loaded++;
   endtask

   // ---------------------------------------------------------------------
   // Random stimulus helpers
   // ---------------------------------------------------------------------
   function automatic wfs_pkg::cfg_type random_settings();
      wfs_pkg::cfg_type c;
      c.range_lo_mm    = 14'($urandom_range(300));
      c.range_hi_mm    = 14'($urandom_range(16383, 2000));
      c.wall_react_mm  = 14'($urandom_range(2000, 150));
      c.wall_danger_mm = 14'($urandom_range(c.wall_react_mm));
      c.wall_dead_band = ($urandom_range(3) == 0) ? 10'($urandom_range(1023))
                                                  : 10'($urandom_range(60));
      c.corner_dist_mm = 14'($urandom_range(3000));
      c.max_step_deg   = ($urandom_range(3) == 0) ? 7'($urandom_range(100))
                                                  : 7'($urandom_range(10));
      c.speed_turn_pct = 7'($urandom_range(100));
      // now and then a narrow or empty window
      if ($urandom_range(9) == 0)
         c.range_lo_mm = 14'($urandom_range(16383));
      return c;
   endfunction

   // distances clustered round the current thresholds
   function automatic logic [13:0] pick_distance();
      int base;
      case ($urandom_range(19))
         0, 1, 2:  return 14'($urandom_range(16383));
         3:        return 14'd0;
         4:        return 14'h3fff;
         5, 6:     base = int'(active_cfg.range_lo_mm);
         7:        base = int'(active_cfg.range_hi_mm);
         8, 9, 10: base = int'(active_cfg.wall_react_mm);
         11, 12:   base = int'(active_cfg.wall_danger_mm);
         13, 14:   base = int'(active_cfg.corner_dist_mm);
         15, 16:   base = int'(active_cfg.wall_react_mm) - int'(active_cfg.wall_dead_band);
         default:  base = int'(active_cfg.wall_react_mm) - int'($urandom_range(400));
      endcase
      base = base + int'($urandom_range(60)) - 30;
      if (base < 0) base = 0;
      if (base > 16383) base = 16383;
      return base[13:0];
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // reset register values: window edges, corners, deadzone, danger
   task automatic test_reset_settings();
      send_reading(14'd0, 14'd0, 14'd0);             // nothing valid
      send_reading(14'h3fff, 14'h3fff, 14'h3fff);    // nothing valid, top of range
      send_reading(14'd1000, 14'd400, 14'd1000);     // left correction
      send_reading(14'd1000, 14'd580, 14'd1000);     // error on the deadzone
      send_reading(14'd1000, 14'd579, 14'd1000);     // just past the deadzone
      send_reading(14'd1000, 14'd1000, 14'd200);     // right correction, capped
      send_reading(14'd1000, 14'd400, 14'd400);      // equal sides, no correction
      send_reading(14'd400, 14'd1000, 14'd2000);     // corner, turn right
      send_reading(14'd400, 14'd2000, 14'd1000);     // corner, turn left
      send_reading(14'd400, 14'd1500, 14'd1500);     // corner, equal sides
      send_reading(14'd400, 14'd50, 14'd9000);       // corner, no side valid
      send_reading(14'd400, 14'd150, 14'd1000);      // danger left during turn
      send_reading(14'd1000, 14'd1000, 14'd150);     // danger right
      send_reading(14'd1000, 14'd150, 14'd150);      // danger both sides
      send_reading(14'd100, 14'd8500, 14'd100);      // window edges
      send_reading(14'd530, 14'd5000, 14'd5000);     // front just off the turn
   endtask

   // register extremes: wide open, frozen angle, empty window
   task automatic test_register_extremes();
      load_settings('{range_lo_mm: 14'd0, range_hi_mm: 14'h3fff,
                      wall_react_mm: 14'h3fff, wall_danger_mm: 14'd0,
                      wall_dead_band: 10'd0, corner_dist_mm: 14'd0,
                      max_step_deg: 7'd100, speed_turn_pct: 7'd100});
      send_reading(14'h3fff, 14'h3fff, 14'd0);
      send_reading(14'd8000, 14'd0, 14'd9000);
      send_reading(14'd0, 14'd0, 14'd0);
      load_settings('{range_lo_mm: 14'd0, range_hi_mm: 14'h3fff,
                      wall_react_mm: 14'd0, wall_danger_mm: 14'h3fff,
                      wall_dead_band: 10'h3ff, corner_dist_mm: 14'h3fff,
                      max_step_deg: 7'd0, speed_turn_pct: 7'd0});
      send_reading(14'd16382, 14'd300, 14'd200);
      send_reading(14'd100, 14'h3fff, 14'h3fff);
      send_reading(14'h3fff, 14'h3fff, 14'h3fff);
      load_settings('{range_lo_mm: 14'h3fff, range_hi_mm: 14'd0,
                      wall_react_mm: 14'd600, wall_danger_mm: 14'd190,
                      wall_dead_band: 10'd20, corner_dist_mm: 14'd530,
                      max_step_deg: 7'd4, speed_turn_pct: 7'd71});
      send_reading(14'd0, 14'd0, 14'd0);
      send_reading(14'd5000, 14'd5000, 14'd5000);
      send_reading(14'h3fff, 14'h3fff, 14'h3fff);
   endtask

   // random readings under random settings across the idling phases
   task automatic test_random_traffic();
      int idle_pct[4]  = '{0, 77, 0, 14};
      int stall_pct[4] = '{0, 0, 77, 14};
      logic [13:0] l;
      logic [13:0] r;
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct    = idle_pct[phase];
         receiver_stall_pct = stall_pct[phase];
         for (int round = 0; round < 6; round++) begin
            load_settings((phase == 0 && round == 0) ? RESET_CFG : random_settings());
            for (int n = 0; n < 60; n++) begin
               l = pick_distance();
               r = ($urandom_range(9) == 0) ? l : pick_distance();
               send_reading(pick_distance(), l, r);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_register_extremes();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (steer_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", steer_q.size()));
      $display("covered %0d requests, %0d results (%0d at turn speed)",
               items_sent, results_seen, turn_results);
      $display("over %0d register settings and four idling phases, %0d mismatches",
               settings_loaded, mismatch_count);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
